### rtl/rpid_pkg.sv
// Shared widths, register codes and word types of the ramped PID controller.
package rpid_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int GAIN_FRAC_BITS = 8;

   localparam int GAIN_BITS = 16;
   localparam int ILIM_BITS = 23;
   localparam int DLIM_BITS = 15;
   localparam int STEP_BITS = 15;

   // derived datapath widths
   localparam int ERR_BITS   = SAMPLE_BITS + 1;
   localparam int DERR_BITS  = SAMPLE_BITS + 2;
   localparam int INTEG_BITS = ((SAMPLE_BITS + 9) > (ILIM_BITS + 1)) ?
                               (SAMPLE_BITS + 9) : (ILIM_BITS + 1);
   localparam int RAMP_BITS  = ((SAMPLE_BITS > STEP_BITS) ? SAMPLE_BITS : STEP_BITS) + 2;
   localparam int PPROD_BITS = GAIN_BITS + ERR_BITS;
   localparam int DPROD_BITS = GAIN_BITS + DERR_BITS;
   localparam int IPROD_BITS = GAIN_BITS + INTEG_BITS;
   localparam int ACC_BITS   = GAIN_BITS + INTEG_BITS + 1;
   localparam int DRV_BITS   = ACC_BITS - GAIN_FRAC_BITS;

   // configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = (ILIM_BITS > SAMPLE_BITS) ? ILIM_BITS : SAMPLE_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] REG_GAIN_PROP      = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GAIN_INTEG     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GAIN_DERIV     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_INTEGRAL_LIMIT = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_DRIVE_LIMIT    = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TARGET_LEVEL   = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] REG_RAMP_INCREMENT = 3'd6;

   typedef struct packed {
      logic [GAIN_BITS-1:0]   gain_prop;
      logic [GAIN_BITS-1:0]   gain_integ;
      logic [GAIN_BITS-1:0]   gain_deriv;
      logic [ILIM_BITS-1:0]   integral_limit;
      logic [DLIM_BITS-1:0]   drive_limit;
      logic [SAMPLE_BITS-1:0] target_level;
      logic [STEP_BITS-1:0]   ramp_increment;
   } cfg_type;

   // error terms leaving the tracking stage (two's complement)
   typedef struct packed {
      logic [ERR_BITS-1:0]    err;
      logic [DERR_BITS-1:0]   derr;
      logic [INTEG_BITS-1:0]  integ;
      logic [SAMPLE_BITS-1:0] setpoint;
   } trk_type;

   // gain products leaving the multiply stage (two's complement)
   typedef struct packed {
      logic [PPROD_BITS-1:0]  p_prod;
      logic [DPROD_BITS-1:0]  d_prod;
      logic [IPROD_BITS-1:0]  i_prod;
      logic [SAMPLE_BITS-1:0] setpoint;
   } prod_type;

endpackage

### rtl/ramped_pid_controller_top.sv
// Top level of the ramped positional PID controller.
//
// One measurement word per control tick enters on req_ (valid/ready); one
// result word (drive, setpoint_used) leaves on rsp_ for every tick, in order.
// Configuration: csr_wr_en writes csr_wr_data to register csr_index at the
// clock edge, no wait; unmapped indexes are ignored. Write only while idle.
//
// Pipeline: input register -> ramp/error/integral stage (loop state lives
// here) -> gain multiply stage -> sum, shift and clamp into the result
// register; each word passes the tracking and gain registers in that order.
// Throughput is one word per cycle while rsp_ready is high; each stage is
// elastic, so the block keeps taking words while earlier results wait, until
// all four registers are full. The one-cycle rate is set by the state loop in
// the tracking stage (ramp step, error and integral clamp update each tick).
//
// A stalled receiver (rsp_ready low) holds rsp_ words steady; the stall
// ripples back and drops req_ready once every stage is occupied.
// Reset (synchronous, active high) zeroes the valid flags, configuration,
// ramped setpoint, previous error and integral, and empties the pipeline.
module ramped_pid_controller_top
   import rpid_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [SAMPLE_BITS-1:0]    req_measurement,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [SAMPLE_BITS-1:0]    rsp_drive,
   output logic [SAMPLE_BITS-1:0]    rsp_setpoint_used,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wr_data
);

   cfg_type                       cfg;
   logic                          in_valid_ff, in_valid_in;
   logic signed [SAMPLE_BITS-1:0] meas_ff;
   logic                          trk_ready, trk_valid, gain_ready, gain_valid, drv_ready;
   logic                          req_load;
   trk_type                       trk_word;
   prod_type                      prod_word;

   rpid_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   // input register
   assign req_ready   = !in_valid_ff || trk_ready;
   assign req_load    = req_valid && req_ready;
   assign in_valid_in = req_load ? 1'b1 : (trk_ready ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_load) begin
         meas_ff <= req_measurement;
      end
   end

   rpid_track u_track (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (in_valid_ff),
      .in_ready  (trk_ready),
      .in_meas   (meas_ff),
      .out_valid (trk_valid),
      .out_ready (gain_ready),
      .out_word  (trk_word)
   );

   rpid_gain u_gain (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (trk_valid),
      .in_ready  (gain_ready),
      .in_word   (trk_word),
      .out_valid (gain_valid),
      .out_ready (drv_ready),
      .out_word  (prod_word)
   );

   rpid_drive u_drive (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .in_valid     (gain_valid),
      .in_ready     (drv_ready),
      .in_word      (prod_word),
      .out_valid    (rsp_valid),
      .out_ready    (rsp_ready),
      .out_drive    (rsp_drive),
      .out_setpoint (rsp_setpoint_used)
   );

endmodule

### rtl/rpid_csr.sv
// Configuration register file of the ramped PID controller.
module rpid_csr
   import rpid_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wr_data,
   output cfg_type                   cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_GAIN_PROP:      cfg_in.gain_prop      = csr_wr_data[GAIN_BITS-1:0];
            REG_GAIN_INTEG:     cfg_in.gain_integ     = csr_wr_data[GAIN_BITS-1:0];
            REG_GAIN_DERIV:     cfg_in.gain_deriv     = csr_wr_data[GAIN_BITS-1:0];
            REG_INTEGRAL_LIMIT: cfg_in.integral_limit = csr_wr_data[ILIM_BITS-1:0];
            REG_DRIVE_LIMIT:    cfg_in.drive_limit    = csr_wr_data[DLIM_BITS-1:0];
            REG_TARGET_LEVEL:   cfg_in.target_level   = csr_wr_data[SAMPLE_BITS-1:0];
            REG_RAMP_INCREMENT: cfg_in.ramp_increment = csr_wr_data[STEP_BITS-1:0];
            default:            cfg_in = cfg_ff;   // unmapped index: ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/rpid_track.sv
// Setpoint ramp, error, derivative and clamped integral; holds the loop state.
module rpid_track
   import rpid_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  cfg_type                       cfg,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [SAMPLE_BITS-1:0] in_meas,
   output logic                          out_valid,
   input  logic                          out_ready,
   output trk_type                       out_word
);

   logic signed [SAMPLE_BITS-1:0] setpoint_ff, setpoint_in;
   logic signed [ERR_BITS-1:0]    prev_err_ff;
   logic signed [INTEG_BITS-1:0]  integ_ff, integ_in;
   logic                          valid_ff, valid_in;
   trk_type                       word_ff;

   logic signed [RAMP_BITS-1:0]    sp_wide, tgt_wide, inc_wide, sp_up, sp_dn, sp_next;
   logic signed [ERR_BITS-1:0]     err_val;
   logic signed [DERR_BITS-1:0]    derr_val;
   logic signed [INTEG_BITS:0]     isum, ilim_pos, ilim_neg, iclamp;
   logic                           load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      sp_wide  = RAMP_BITS'(setpoint_ff);
      tgt_wide = RAMP_BITS'($signed(cfg.target_level));
      inc_wide = RAMP_BITS'(cfg.ramp_increment);
      sp_up    = sp_wide + inc_wide;
      sp_dn    = sp_wide - inc_wide;
      // step toward the target, landing on it rather than passing it
      if (sp_wide < tgt_wide) begin
         sp_next = (sp_up >= tgt_wide) ? tgt_wide : sp_up;
      end else if (sp_wide > tgt_wide) begin
         sp_next = (sp_dn <= tgt_wide) ? tgt_wide : sp_dn;
      end else begin
         sp_next = sp_wide;
      end
      setpoint_in = sp_next[SAMPLE_BITS-1:0];

      err_val  = ERR_BITS'(setpoint_in) - ERR_BITS'(in_meas);
      derr_val = DERR_BITS'(err_val) - DERR_BITS'(prev_err_ff);

      isum     = (INTEG_BITS+1)'(integ_ff) + (INTEG_BITS+1)'(err_val);
      ilim_pos = (INTEG_BITS+1)'(cfg.integral_limit);
      ilim_neg = -ilim_pos;
      if (isum > ilim_pos) begin
         iclamp = ilim_pos;
      end else if (isum < ilim_neg) begin
         iclamp = ilim_neg;
      end else begin
         iclamp = isum;
      end
      integ_in = iclamp[INTEG_BITS-1:0];

      valid_in = load ? 1'b1 : (out_ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff <= '0;
         prev_err_ff <= '0;
         integ_ff    <= '0;
         valid_ff    <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (load) begin
            setpoint_ff <= setpoint_in;
            prev_err_ff <= err_val;
            integ_ff    <= integ_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff.err      <= err_val;
         word_ff.derr     <= derr_val;
         word_ff.integ    <= integ_in;
         word_ff.setpoint <= setpoint_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   a_integ_bound: assert property (@(posedge clock) disable iff (reset)
      load |=> (integ_ff <= $signed({1'b0, $past(cfg.integral_limit)})) &&
               (integ_ff >= -$signed({1'b0, $past(cfg.integral_limit)})))
      else $error("integral outside its limit");

   a_ramp_hold: assert property (@(posedge clock) disable iff (reset)
      load && (sp_wide == tgt_wide) |=> $stable(setpoint_ff))
      else $error("setpoint moved while on target");

   a_ramp_no_overshoot: assert property (@(posedge clock) disable iff (reset)
      load && (sp_wide < tgt_wide) |=> setpoint_ff <= $signed($past(cfg.target_level)))
      else $error("rising ramp passed the target");

endmodule

### rtl/rpid_gain.sv
// Gain multiply stage: one registered product per term.
module rpid_gain
   import rpid_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     in_valid,
   output logic     in_ready,
   input  trk_type  in_word,
   output logic     out_valid,
   input  logic     out_ready,
   output prod_type out_word
);

   logic signed [GAIN_BITS-1:0]  kp, ki, kd;
   logic signed [ERR_BITS-1:0]   e;
   logic signed [DERR_BITS-1:0]  de;
   logic signed [INTEG_BITS-1:0] ig;
   logic signed [PPROD_BITS-1:0] p_val;
   logic signed [DPROD_BITS-1:0] d_val;
   logic signed [IPROD_BITS-1:0] i_val;
   logic                         valid_ff, valid_in, load;
   prod_type                     word_ff;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      kp    = cfg.gain_prop;
      ki    = cfg.gain_integ;
      kd    = cfg.gain_deriv;
      e     = in_word.err;
      de    = in_word.derr;
      ig    = in_word.integ;
      p_val = kp * e;
      d_val = kd * de;
      i_val = ki * ig;
      valid_in = load ? 1'b1 : (out_ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff.p_prod   <= p_val;
         word_ff.d_prod   <= d_val;
         word_ff.i_prod   <= i_val;
         word_ff.setpoint <= in_word.setpoint;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

### rtl/rpid_drive.sv
// Sum of products, Q8.8 scaling, drive clamp and result register.
module rpid_drive
   import rpid_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  cfg_type                cfg,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  prod_type               in_word,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [SAMPLE_BITS-1:0] out_drive,
   output logic [SAMPLE_BITS-1:0] out_setpoint
);

   logic signed [ACC_BITS-1:0]  acc;
   logic signed [DRV_BITS-1:0]  drv_raw, dlim_pos, dlim_neg, drv_c;
   logic [SAMPLE_BITS-1:0]      drive_ff, drive_in, setpoint_ff;
   logic                        valid_ff, valid_in, load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_comb begin
      acc = ACC_BITS'($signed(in_word.p_prod)) + ACC_BITS'($signed(in_word.d_prod))
          + ACC_BITS'($signed(in_word.i_prod));
      // arithmetic shift: rounds toward minus infinity
      drv_raw  = DRV_BITS'(acc >>> GAIN_FRAC_BITS);
      dlim_pos = DRV_BITS'(cfg.drive_limit);
      dlim_neg = -dlim_pos;
      if (drv_raw > dlim_pos) begin
         drv_c = dlim_pos;
      end else if (drv_raw < dlim_neg) begin
         drv_c = dlim_neg;
      end else begin
         drv_c = drv_raw;
      end
      drive_in = drv_c[SAMPLE_BITS-1:0];
      valid_in = load ? 1'b1 : (out_ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         drive_ff    <= drive_in;
         setpoint_ff <= in_word.setpoint;
      end
   end

   assign out_valid    = valid_ff;
   assign out_drive    = drive_ff;
   assign out_setpoint = setpoint_ff;

   a_drive_bound: assert property (@(posedge clock) disable iff (reset)
      load |=> ($signed(drive_ff) <= $signed({1'b0, $past(cfg.drive_limit)})) &&
               ($signed(drive_ff) >= -$signed({1'b0, $past(cfg.drive_limit)})))
      else $error("drive outside its limit");

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the ramped PID controller: directed and random ticks, scored in order.
module testbench
   import rpid_pkg::*;
();

   // long receiver stall, in cycles, to fill the pipeline and stall req_
   localparam int HOLD_CYCLES     = 120;
   // cycles without any handshake or register write before giving up
   localparam int WATCHDOG_LIMIT  = 4000;
   localparam int RANDOM_PHASES   = 6;
   localparam int ITEMS_PER_PHASE = 105;
   // an index past the register map; writes to it must be dropped
   localparam logic [CSR_INDEX_BITS-1:0] REG_UNMAPPED = 3'd7;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] drive;
      logic [SAMPLE_BITS-1:0] setpoint;
   } tick_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [SAMPLE_BITS-1:0]    req_measurement = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [SAMPLE_BITS-1:0]    rsp_drive;
   logic [SAMPLE_BITS-1:0]    rsp_setpoint_used;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wr_data = '0;

   // measurement words waiting to be offered, and results still owed by the block
   logic [SAMPLE_BITS-1:0] meas_pending[$];
   tick_result_type        drive_due[$];

   int send_idle_pct = 16;
   int recv_idle_pct = 66;
   int mismatch_count = 0;
   int stall_cycles = 0;
   int hold_left = 0;
   int words_taken = 0;

   // controller state as the testbench sees it
   cfg_type cfg_model = '0;
   longint  track_setpoint = 0;
   longint  last_error = 0;
   longint  error_sum = 0;

   ramped_pid_controller_top u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_measurement   (req_measurement),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_drive         (rsp_drive),
      .rsp_setpoint_used (rsp_setpoint_used),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // One control tick: ramp, error, clamped integral, Q8.8 sum, floor shift, drive clamp.
   function automatic tick_result_type controller_tick(logic [SAMPLE_BITS-1:0] meas_word);
      longint          meas, target, kp, ki, kd, ilim, dlim, err, acc, drv;
      tick_result_type res;
      meas   = longint'($signed(meas_word));
      target = longint'($signed(cfg_model.target_level));
      kp     = longint'($signed(cfg_model.gain_prop));
      ki     = longint'($signed(cfg_model.gain_integ));
      kd     = longint'($signed(cfg_model.gain_deriv));
      ilim   = longint'(cfg_model.integral_limit);
      dlim   = longint'(cfg_model.drive_limit);

      // setpoint steps toward the target and lands on it exactly
      if (track_setpoint < target) begin
         track_setpoint += longint'(cfg_model.ramp_increment);
         if (track_setpoint >= target) track_setpoint = target;
      end else if (track_setpoint > target) begin
         track_setpoint -= longint'(cfg_model.ramp_increment);
         if (track_setpoint <= target) track_setpoint = target;
      end

      err = track_setpoint - meas;
      error_sum += err;
      if (error_sum > ilim) error_sum = ilim;
      else if (error_sum < -ilim) error_sum = -ilim;

      acc = kp * err + kd * (err - last_error) + ki * error_sum;
      drv = acc >>> GAIN_FRAC_BITS;
      if (drv > dlim) drv = dlim;
      else if (drv < -dlim) drv = -dlim;
      last_error = err;

      res.drive    = drv[SAMPLE_BITS-1:0];
      res.setpoint = track_setpoint[SAMPLE_BITS-1:0];
      return res;
   endfunction

   // register file copy; bits above each register's width fall away
   function automatic void apply_reg(logic [CSR_INDEX_BITS-1:0] idx,
                                     logic [CSR_DATA_BITS-1:0] data);
      case (idx)
         REG_GAIN_PROP:      cfg_model.gain_prop      = data[GAIN_BITS-1:0];
         REG_GAIN_INTEG:     cfg_model.gain_integ     = data[GAIN_BITS-1:0];
         REG_GAIN_DERIV:     cfg_model.gain_deriv     = data[GAIN_BITS-1:0];
         REG_INTEGRAL_LIMIT: cfg_model.integral_limit = data[ILIM_BITS-1:0];
         REG_DRIVE_LIMIT:    cfg_model.drive_limit    = data[DLIM_BITS-1:0];
         REG_TARGET_LEVEL:   cfg_model.target_level   = data[SAMPLE_BITS-1:0];
         REG_RAMP_INCREMENT: cfg_model.ramp_increment = data[STEP_BITS-1:0];
         default: ;
      endcase
   endfunction

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      apply_reg(idx, data);
   endtask

   task automatic flag_mismatch(input string what, input logic [SAMPLE_BITS-1:0] got,
                                input logic [SAMPLE_BITS-1:0] want);
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, $signed(got),
               $signed(want), $realtime);
      mismatch_count++;
   endtask

   // Wait until every word has gone in and every result has come out, so the
   // pipeline is surely empty before a register write.
   task automatic drain;
      while (meas_pending.size() != 0 || req_valid || drive_due.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Mostly gains of modest size so the drive is not always pinned, with the
   // extremes mixed in; junk above each register's width on every write.
   function automatic logic [GAIN_BITS-1:0] pick_gain;
      case ($urandom_range(9))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'h0000;
         default: return 16'($urandom_range(2047)) - 16'd1024;
      endcase
   endfunction

   task automatic random_setup(input int phase);
      logic [ILIM_BITS-1:0]   ilim;
      logic [DLIM_BITS-1:0]   dlim;
      logic [STEP_BITS-1:0]   step;
      case ($urandom_range(4))
         0:       ilim = '0;
         1:       ilim = '1;
         default: ilim = 23'($urandom_range(200000));
      endcase
      // wide-open integral, then a tight one: the limit drops under a live integral
      if (phase == 2) ilim = '1;
      if (phase == 3) ilim = 23'($urandom_range(200));
      case ($urandom_range(4))
         0:       dlim = '0;
         1:       dlim = '1;
         default: dlim = 15'($urandom_range(32767, 1000));
      endcase
      case ($urandom_range(4))
         0:       step = '0;
         1:       step = '1;
         default: step = 15'($urandom_range(3000, 1));
      endcase
      write_reg(REG_GAIN_PROP,      {7'($urandom), pick_gain()});
      write_reg(REG_GAIN_INTEG,     {7'($urandom), pick_gain()});
      write_reg(REG_GAIN_DERIV,     {7'($urandom), pick_gain()});
      write_reg(REG_INTEGRAL_LIMIT, ilim);
      write_reg(REG_DRIVE_LIMIT,    {8'($urandom), dlim});
      write_reg(REG_TARGET_LEVEL,   {7'($urandom), 16'($urandom)});
      write_reg(REG_RAMP_INCREMENT, {8'($urandom), step});
      if ($urandom_range(3) == 0) write_reg(REG_UNMAPPED, 23'($urandom));
   endtask

   // Measurements mostly hover around the target, as a loop settling would;
   // a quarter are anywhere in range.
   function automatic logic [SAMPLE_BITS-1:0] pick_meas;
      if ($urandom_range(3) == 0) return 16'($urandom);
      return cfg_model.target_level + 16'($urandom_range(1023)) - 16'd512;
   endfunction

   // Driver: offers the next word when the channel is free; the tick is
   // predicted at the edge the word is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) drive_due.push_back(controller_tick(req_measurement));
         if (meas_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid       <= 1'b1;
            req_measurement <= meas_pending.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random ready, plus two long hold-offs while words keep coming.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready   <= 1'b0;
         hold_left   <= 0;
         words_taken <= 0;
      end else begin
         if (rsp_valid && rsp_ready) words_taken <= words_taken + 1;
         if (hold_left != 0) begin
            rsp_ready <= 1'b0;
            hold_left <= hold_left - 1;
         end else if (rsp_valid && rsp_ready && (words_taken == 150 || words_taken == 450)) begin
            rsp_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Scoreboard: each result word against the oldest prediction.
   always @(posedge clock) begin : check_rsp
      tick_result_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         if (drive_due.size() == 0) begin
            flag_mismatch("result word with nothing outstanding", rsp_drive, '0);
         end else begin
            due = drive_due.pop_front();
            if (rsp_drive !== due.drive) flag_mismatch("drive", rsp_drive, due.drive);
            if (rsp_setpoint_used !== due.setpoint)
               flag_mismatch("setpoint_used", rsp_setpoint_used, due.setpoint);
         end
      end
   end

   // Watchdog: any handshake or register write counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_wr_en) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin : run_sequence
      int phase;
      int n;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Ramp of 300 toward 1000 lands on the target at the fourth tick;
      // drive limit written with all-ones data, unmapped index written too.
      write_reg(REG_GAIN_PROP,      23'h000100);
      write_reg(REG_GAIN_INTEG,     23'h000010);
      write_reg(REG_GAIN_DERIV,     23'h000040);
      write_reg(REG_INTEGRAL_LIMIT, 23'd1000);
      write_reg(REG_DRIVE_LIMIT,    23'h7FFFFF);
      write_reg(REG_TARGET_LEVEL,   23'd1000);
      write_reg(REG_RAMP_INCREMENT, 23'd300);
      write_reg(REG_UNMAPPED,       23'h12345);
      @(negedge clock);
      repeat (4) meas_pending.push_back(16'h0000);
      meas_pending.push_back(16'h8000);
      meas_pending.push_back(16'h7FFF);
      meas_pending.push_back(16'hFFFF);
      meas_pending.push_back(16'h0001);
      meas_pending.push_back(16'h5555);
      meas_pending.push_back(16'hAAAA);
      drain();

      // Extreme gains but zero drive and integral limits, zero ramp step:
      // drive must read 0, setpoint must stay put though the target moved.
      write_reg(REG_GAIN_PROP,      23'h008000);
      write_reg(REG_GAIN_INTEG,     23'h007FFF);
      write_reg(REG_GAIN_DERIV,     23'h008000);
      write_reg(REG_INTEGRAL_LIMIT, 23'd0);
      write_reg(REG_DRIVE_LIMIT,    23'd0);
      write_reg(REG_TARGET_LEVEL,   23'h408000);
      write_reg(REG_RAMP_INCREMENT, 23'd0);
      @(negedge clock);
      meas_pending.push_back(16'h7FFF);
      meas_pending.push_back(16'h8000);
      meas_pending.push_back(16'h0000);
      drain();

      // Full-scale step toward the top rail overshoots and clamps there;
      // largest proportional and derivative gains and open integral push the widest sums.
      write_reg(REG_GAIN_PROP,      23'h007FFF);
      write_reg(REG_GAIN_INTEG,     23'h000001);
      write_reg(REG_GAIN_DERIV,     23'h007FFF);
      write_reg(REG_INTEGRAL_LIMIT, 23'h7FFFFF);
      write_reg(REG_DRIVE_LIMIT,    23'h007FFF);
      write_reg(REG_TARGET_LEVEL,   23'h007FFF);
      write_reg(REG_RAMP_INCREMENT, 23'h007FFF);
      @(negedge clock);
      meas_pending.push_back(16'h8000);
      meas_pending.push_back(16'h8000);
      meas_pending.push_back(16'h7FFF);
      meas_pending.push_back(16'h8000);
      meas_pending.push_back(16'h0000);
      meas_pending.push_back(16'h0000);
      drain();

      // integral limit cut under a large integral: clamp on the next tick
      write_reg(REG_INTEGRAL_LIMIT, 23'd10);
      @(negedge clock);
      meas_pending.push_back(16'h0000);
      meas_pending.push_back(16'h8000);
      meas_pending.push_back(16'h7FFF);
      drain();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         random_setup(phase);
         @(negedge clock);
         if (phase < 2) begin
            send_idle_pct = 16;
            recv_idle_pct = 66;
         end else if (phase < 4) begin
            send_idle_pct = 66;
            recv_idle_pct = 16;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         for (n = 0; n < ITEMS_PER_PHASE; n++) meas_pending.push_back(pick_meas());
         drain();
      end

      repeat (10) @(posedge clock);
      if (drive_due.size() != 0) flag_mismatch("results never delivered", '0, '0);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/rpid_pkg.sv
rtl/rpid_csr.sv
rtl/rpid_track.sv
rtl/rpid_gain.sv
rtl/rpid_drive.sv
rtl/ramped_pid_controller_top.sv
test/testbench.sv
